@@ src/enbid_pkg.sv @@
// Package for the ELF note build id scanner.
// Holds the phase encoding, status codes, result word layout and hex digit lookup.
// No dependencies.
package enbid_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned POS_W   = LEN_W + 1;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned HEX_W   = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OUT_W   = 16;

  localparam logic [CNT_W-1:0] HDR_NAME_DONE = 4'd4;
  localparam logic [CNT_W-1:0] HDR_DESC_DONE = 4'd8;
  localparam logic [CNT_W-1:0] HDR_TYPE_DONE = 4'd12;

  localparam logic [LEN_W-1:0] BUILD_ID_TYPE = 32'd3;
  localparam logic [LEN_W-1:0] GNU_NAME_LEN  = 32'd3;

  localparam logic [BYTE_W-1:0] CHAR_G = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_N = 8'h4e;
  localparam logic [BYTE_W-1:0] CHAR_U = 8'h55;

  typedef enum logic [STAT_W-1:0] {
    ST_PENDING   = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    PH_HEADER    = 5'b00001,
    PH_NAME      = 5'b00010,
    PH_DESC_SKIP = 5'b00100,
    PH_DESC_EMIT = 5'b01000,
    PH_DONE      = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              has_pair;
    logic [HEX_W-1:0]  hex_high;
    logic [HEX_W-1:0]  hex_low;
    logic [STAT_W-1:0] status;
  } result_t;

  function automatic logic [HEX_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 7'h30 + {3'b000, nib};
    end else begin
      return 7'h57 + {3'b000, nib};
    end
  endfunction

endpackage

@@ src/elf_note_build_id_scan.sv @@
// ELF note segment scanner that extracts the GNU build id as hex characters.
// Depends on enbid_pkg for the phase encoding, status codes and hex lookup.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_tvalid/in_tready   | tdata[7:0] seg_byte, tlast block_last
//  out_    | output    | out_tvalid/out_tready | tuser has_pair, tdata hex/status
//  cfg_    | input     | cfg_valid/cfg_ready   | cfg_data big_endian
//
// One word is accepted per cycle while in_tready is high; its result is registered.
// A result register and a skid register decouple the two sides, so in_tready
// only drops while the skid register holds a word.
// Reset is synchronous and active low; it clears all scan state and big_endian.
// The configuration port is always ready.
module elf_note_build_id_scan (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [enbid_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] seg_byte
  input  logic                           in_tlast,   // block_last
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [enbid_pkg::OUT_W-1:0]    out_tdata,  // [6:0] hex_high, [13:7] hex_low,
                                                     // [15:14] status
  output logic                           out_tuser,  // has_pair
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data    // big_endian
);
  import enbid_pkg::*;

  logic              big_endian_r;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [LEN_W-1:0]  word_r, word_nxt;
  logic [LEN_W-1:0]  name_len_r, name_len_nxt;
  logic [LEN_W-1:0]  desc_len_r, desc_len_nxt;
  logic              type_bid_r, type_bid_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              name_ok_r, name_ok_nxt;
  logic              found_r, found_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  result_t           out_data_r, skid_data_r;

  logic              accept;
  logic              out_take;
  logic              res_valid;
  result_t           res;
  logic [LEN_W-1:0]  word_shift;
  logic [CNT_W-1:0]  cnt_inc;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  name_pad;
  logic [POS_W-1:0]  desc_pad;
  logic [BYTE_W-1:0] want;
  logic              match;
  logic              found_now;
  logic              pair;

  assign in_tready  = !skid_valid_r;
  assign cfg_ready  = 1'b1;
  assign accept     = in_tvalid && in_tready;
  assign out_take   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.has_pair;
  assign out_tdata  = {out_data_r.status, out_data_r.hex_low, out_data_r.hex_high};

  assign name_pad = {({1'b0, name_len_r[LEN_W-1:2]} + (LEN_W-1)'(|name_len_r[1:0])), 2'b00};
  assign desc_pad = {({1'b0, desc_len_r[LEN_W-1:2]} + (LEN_W-1)'(|desc_len_r[1:0])), 2'b00};
  assign pos_inc  = pos_r + POS_W'(1);
  assign cnt_inc  = hdr_cnt_r + CNT_W'(1);
  assign word_shift = big_endian_r ? {word_r[LEN_W-BYTE_W-1:0], in_tdata}
                                   : {in_tdata, word_r[LEN_W-1:BYTE_W]};

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    word_nxt     = word_r;
    name_len_nxt = name_len_r;
    desc_len_nxt = desc_len_r;
    type_bid_nxt = type_bid_r;
    pos_nxt      = pos_r;
    name_ok_nxt  = name_ok_r;
    found_nxt    = found_r;
    found_now    = 1'b0;
    pair         = 1'b0;
    match        = 1'b0;
    want         = '0;
    res          = '0;

    if (pos_r == POS_W'(0)) begin
      want = CHAR_G;
    end else if (pos_r == POS_W'(1)) begin
      want = CHAR_N;
    end else if (pos_r == POS_W'(2)) begin
      want = CHAR_U;
    end

    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          word_nxt    = word_shift;
          hdr_cnt_nxt = cnt_inc;
          if (cnt_inc == HDR_NAME_DONE) begin
            name_len_nxt = word_shift;
          end else if (cnt_inc == HDR_DESC_DONE) begin
            desc_len_nxt = word_shift;
          end else if (cnt_inc >= HDR_TYPE_DONE) begin
            type_bid_nxt = (word_shift == BUILD_ID_TYPE);
            hdr_cnt_nxt  = '0;
            word_nxt     = '0;
            name_ok_nxt  = 1'b1;
            pos_nxt      = '0;
            if (name_len_r == '0) begin
              phase_nxt = (desc_len_r == '0) ? PH_HEADER : PH_DESC_SKIP;
            end else begin
              phase_nxt = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (pos_r < {1'b0, name_len_r} && in_tdata != want) begin
            name_ok_nxt = 1'b0;
          end
          pos_nxt = pos_inc;
          if (pos_inc >= name_pad) begin
            match   = type_bid_r && name_ok_nxt && (name_len_r >= GNU_NAME_LEN);
            pos_nxt = '0;
            if (desc_len_r == '0) begin
              if (match) begin
                phase_nxt = PH_DONE;
                found_nxt = 1'b1;
                found_now = 1'b1;
              end else begin
                phase_nxt = PH_HEADER;
              end
            end else begin
              phase_nxt = match ? PH_DESC_EMIT : PH_DESC_SKIP;
            end
          end
        end
        PH_DESC_SKIP, PH_DESC_EMIT: begin
          if (phase_r == PH_DESC_EMIT && pos_r < {1'b0, desc_len_r}) begin
            pair = 1'b1;
          end
          pos_nxt = pos_inc;
          if (pos_inc >= desc_pad) begin
            pos_nxt = '0;
            if (phase_r == PH_DESC_EMIT) begin
              found_nxt = 1'b1;
              found_now = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase

      res.has_pair = pair;
      if (pair) begin
        res.hex_high = hex_char(in_tdata[7:4]);
        res.hex_low  = hex_char(in_tdata[3:0]);
      end
      if (found_now) begin
        res.status = ST_FOUND;
      end else if (in_tlast && !found_r) begin
        res.status = ST_NOT_FOUND;
      end else begin
        res.status = ST_PENDING;
      end

      if (in_tlast) begin
        phase_nxt    = PH_HEADER;
        hdr_cnt_nxt  = '0;
        word_nxt     = '0;
        name_len_nxt = '0;
        desc_len_nxt = '0;
        type_bid_nxt = 1'b0;
        pos_nxt      = '0;
        name_ok_nxt  = 1'b1;
        found_nxt    = 1'b0;
      end
    end
  end

  assign res_valid = accept && (res.has_pair || res.status != ST_PENDING);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_take) begin
        skid_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
      phase_r      <= PH_HEADER;
      hdr_cnt_r    <= '0;
      word_r       <= '0;
      name_len_r   <= '0;
      desc_len_r   <= '0;
      type_bid_r   <= 1'b0;
      pos_r        <= '0;
      name_ok_r    <= 1'b1;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        big_endian_r <= cfg_data;
      end
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      word_r       <= word_nxt;
      name_len_r   <= name_len_nxt;
      desc_len_r   <= desc_len_nxt;
      type_bid_r   <= type_bid_nxt;
      pos_r        <= pos_nxt;
      name_ok_r    <= name_ok_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_take) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

endmodule

@@ src/enbid_chk.sv @@
// Port-level checker for the ELF note build id scanner, bound to the top level.
// Depends on enbid_pkg for the status codes.
module enbid_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [enbid_pkg::OUT_W-1:0]  out_tdata,
  input logic                         out_tuser
);
  import enbid_pkg::*;

  logic [STAT_W-1:0] status;
  logic [HEX_W-1:0]  hex_high;
  logic [HEX_W-1:0]  hex_low;

  assign hex_high = out_tdata[HEX_W-1:0];
  assign hex_low  = out_tdata[2*HEX_W-1:HEX_W];
  assign status   = out_tdata[OUT_W-1:2*HEX_W];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output word changed or was dropped.");

  a_word_meaningful: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser || status == ST_FOUND || status == ST_NOT_FOUND)
    else $error("Output word carries neither a pair nor a status.");

  a_hex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> hex_high == '0 && hex_low == '0)
    else $error("Hex fields are set without a pair.");

  a_ready_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tvalid && out_tready |=> in_tready)
    else $error("Input stays blocked after the output drained.");

endmodule

bind elf_note_build_id_scan enbid_chk u_enbid_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ verif/elf_note_build_id_scan_tb.sv @@
// Self-checking testbench for elf_note_build_id_scan: note segments in both header byte orders,
// random flow control on both stream sides and a cycle-free predictor of the result words.
// Depends on enbid_pkg and the elf_note_build_id_scan RTL only.
`timescale 1ns / 1ps

module elf_note_build_id_scan_tb;
  import enbid_pkg::*;

  localparam logic [127:0] HEX_CHARS = "0123456789abcdef";
  localparam int BODY_CAP = 64;
  localparam int PHASE_BYTES = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } seg_word_t;

  typedef enum int {NAME_GNU, NAME_CORRUPT, NAME_RANDOM} name_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;

  seg_word_t  seg_tx_q[$];
  logic [7:0] seg_buf[$];
  result_t    scan_result_q[$];
  int         bytes_queued = 0;
  int         bytes_taken = 0;
  int         mismatches = 0;

  // Predictor state.
  logic        cfg_big_endian;
  phase_t      scan_phase;
  logic [3:0]  hdr_count;
  logic [31:0] hdr_word;
  logic [31:0] name_len;
  logic [31:0] desc_len;
  logic        is_build_id;
  logic        name_ok;
  logic        id_found;
  logic [33:0] region_pos;

  // Flow control state.
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  elf_note_build_id_scan uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [33:0] pad_to_word(input logic [31:0] len);
    return ({2'b00, len} + 34'd3) & ~34'd3;
  endfunction

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    return HEX_CHARS[8 * (4'd15 - nib) +: 7];
  endfunction

  function automatic void clear_scan();
    scan_phase = PH_HEADER;
    hdr_count = '0;
    hdr_word = '0;
    name_len = '0;
    desc_len = '0;
    is_build_id = 1'b0;
    region_pos = '0;
    name_ok = 1'b1;
    id_found = 1'b0;
  endfunction

  // Moves into the descriptor; a matching note with an empty descriptor is found at once.
  function automatic logic open_desc(input logic match);
    region_pos = '0;
    if (pad_to_word(desc_len) == 34'd0) begin
      scan_phase = PH_HEADER;
      if (match) begin
        scan_phase = PH_DONE;
        id_found = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    scan_phase = match ? PH_DESC_EMIT : PH_DESC_SKIP;
    return 1'b0;
  endfunction

  function automatic void predict_build_id_byte(input logic [7:0] b, input logic last);
    result_t    r;
    logic       found_now;
    logic [7:0] want;
    logic       match;
    r = '0;
    found_now = 1'b0;
    case (scan_phase)
      PH_HEADER: begin
        hdr_word = cfg_big_endian ? {hdr_word[23:0], b} : {b, hdr_word[31:8]};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count == HDR_NAME_DONE) begin
          name_len = hdr_word;
        end else if (hdr_count == HDR_DESC_DONE) begin
          desc_len = hdr_word;
        end else if (hdr_count >= HDR_TYPE_DONE) begin
          is_build_id = (hdr_word == BUILD_ID_TYPE);
          hdr_count = '0;
          hdr_word = '0;
          name_ok = 1'b1;
          region_pos = '0;
          if (pad_to_word(name_len) == 34'd0) begin
            found_now = open_desc(1'b0);
          end else begin
            scan_phase = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (region_pos < {2'b00, name_len}) begin
          case (region_pos)
            34'd0: want = CHAR_G;
            34'd1: want = CHAR_N;
            34'd2: want = CHAR_U;
            default: want = 8'h00;
          endcase
          if (b != want) begin
            name_ok = 1'b0;
          end
        end
        region_pos = region_pos + 34'd1;
        if (region_pos >= pad_to_word(name_len)) begin
          match = is_build_id && name_ok && (name_len >= GNU_NAME_LEN);
          found_now = open_desc(match);
        end
      end
      PH_DESC_SKIP, PH_DESC_EMIT: begin
        if (scan_phase == PH_DESC_EMIT && region_pos < {2'b00, desc_len}) begin
          r.has_pair = 1'b1;
          r.hex_high = hex_digit(b[7:4]);
          r.hex_low = hex_digit(b[3:0]);
        end
        region_pos = region_pos + 34'd1;
        if (region_pos >= pad_to_word(desc_len)) begin
          if (scan_phase == PH_DESC_EMIT) begin
            id_found = 1'b1;
            found_now = 1'b1;
            scan_phase = PH_DONE;
          end else begin
            scan_phase = PH_HEADER;
          end
          region_pos = '0;
        end
      end
      default: begin
      end
    endcase
    if (found_now) begin
      r.status = ST_FOUND;
    end else if (last && !id_found) begin
      r.status = ST_NOT_FOUND;
    end else begin
      r.status = ST_PENDING;
    end
    if (last) begin
      clear_scan();
    end
    if (r.has_pair || r.status != ST_PENDING) begin
      scan_result_q.insert(scan_result_q.size(), r);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Byte driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : byte_driver
    seg_word_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_build_id_byte(in_tdata, in_tlast);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (seg_tx_q.size() > 0) begin
          item = seg_tx_q.pop_front();
          in_tdata <= item.data;
          in_tlast <= item.last;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with its own stall pattern.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (scan_result_q.size() == 0) begin
          report_mismatch("result word with nothing expected", {out_tuser, out_tdata[14:0]},
                          16'h0000);
        end else begin
          want = scan_result_q.pop_front();
          if (out_tuser !== want.has_pair) begin
            report_mismatch("has_pair", {15'd0, out_tuser}, {15'd0, want.has_pair});
          end
          if (out_tdata[6:0] !== want.hex_high) begin
            report_mismatch("hex_high", {9'd0, out_tdata[6:0]}, {9'd0, want.hex_high});
          end
          if (out_tdata[13:7] !== want.hex_low) begin
            report_mismatch("hex_low", {9'd0, out_tdata[13:7]}, {9'd0, want.hex_low});
          end
          if (out_tdata[15:14] !== want.status) begin
            report_mismatch("status", {14'd0, out_tdata[15:14]}, {14'd0, want.status});
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 80);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic write_big_endian(input logic value);
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_big_endian = value;
  endtask

  task automatic wait_scan_idle();
    while (bytes_taken != bytes_queued || scan_result_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic put_word(input logic [31:0] w, input logic be);
    for (int i = 0; i < 4; i++) begin
      seg_buf.insert(seg_buf.size(), be ? w[31 - 8 * i -: 8] : w[8 * i +: 8]);
    end
  endtask

  task automatic flush_segment();
    seg_word_t item;
    for (int i = 0; i < seg_buf.size(); i++) begin
      item.data = seg_buf[i];
      item.last = (i == seg_buf.size() - 1);
      seg_tx_q.insert(seg_tx_q.size(), item);
    end
    bytes_queued += seg_buf.size();
    seg_buf.delete();
  endtask

  // Regions longer than BODY_CAP are cut short; the segment ends inside them.
  task automatic add_note(input logic [31:0] nlen, input name_kind_t kind,
                          input logic [31:0] dlen, input logic [31:0] ntype, input logic be);
    int         bad_at;
    logic [7:0] b;
    put_word(nlen, be);
    put_word(dlen, be);
    put_word(ntype, be);
    bad_at = -1;
    if (kind == NAME_CORRUPT && nlen != 0) begin
      bad_at = int'($urandom_range(0, (nlen < BODY_CAP) ? nlen - 1 : BODY_CAP - 1));
    end
    for (int i = 0; i < pad_to_word(nlen) && i < BODY_CAP; i++) begin
      if (i < nlen) begin
        case (i)
          0: b = CHAR_G;
          1: b = CHAR_N;
          2: b = CHAR_U;
          default: b = 8'h00;
        endcase
        if (kind == NAME_RANDOM) begin
          b = 8'($urandom_range(0, 255));
        end
        if (i == bad_at) begin
          b = b ^ 8'($urandom_range(1, 255));
        end
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      seg_buf.insert(seg_buf.size(), b);
    end
    for (int i = 0; i < pad_to_word(dlen) && i < BODY_CAP; i++) begin
      seg_buf.insert(seg_buf.size(), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_segment(input logic be);
    int          notes;
    int          id_at;
    int          cut;
    logic        note_be;
    logic [31:0] nlen;
    logic [31:0] dlen;
    logic [31:0] ntype;
    name_kind_t  kind;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) seg_buf.insert(seg_buf.size(), 8'($urandom_range(0, 255)));
    end else begin
      notes = $urandom_range(1, 3);
      id_at = ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, notes - 1);
      for (int k = 0; k < notes; k++) begin
        note_be = ($urandom_range(0, 9) == 0) ? !be : be;
        if (k == id_at) begin
          nlen = ($urandom_range(0, 3) != 0) ? 32'd4 : $urandom_range(0, 8);
          kind = ($urandom_range(0, 4) == 0) ? NAME_CORRUPT : NAME_GNU;
          dlen = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 20);
          ntype = BUILD_ID_TYPE;
        end else begin
          nlen = $urandom_range(0, 8);
          kind = name_kind_t'($urandom_range(0, 2));
          dlen = $urandom_range(0, 12);
          case ($urandom_range(0, 3))
            0: ntype = BUILD_ID_TYPE;
            1: ntype = $urandom_range(1, 2);
            2: ntype = $urandom();
            default: ntype = 32'hffff_ffff;
          endcase
        end
        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            nlen = 32'hffff_ffff - $urandom_range(0, 3);
          end else begin
            dlen = $urandom();
          end
          add_note(nlen, kind, dlen, ntype, note_be);
          break;
        end
        add_note(nlen, kind, dlen, ntype, note_be);
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 6)) seg_buf.insert(seg_buf.size(), 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, seg_buf.size());
        while (seg_buf.size() > cut) seg_buf.pop_back();
      end
    end
    flush_segment();
  endtask

  initial begin : stimulus
    logic be_plan[4];
    int   phase_start;
    be_plan = '{1'b1, 1'b0, 1'b1, 1'b0};
    cfg_big_endian = 1'b0;
    clear_scan();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_big_endian(1'b0);

    @(negedge clk);
    // A lone byte ends the segment inside a header.
    seg_buf.insert(seg_buf.size(), 8'h00);
    flush_segment();
    // Three-byte GNU name with unchecked padding; the last descriptor byte ends the segment.
    put_word(32'd3, 1'b0);
    put_word(32'd4, 1'b0);
    put_word(BUILD_ID_TYPE, 1'b0);
    seg_buf.insert(seg_buf.size(), CHAR_G);
    seg_buf.insert(seg_buf.size(), CHAR_N);
    seg_buf.insert(seg_buf.size(), CHAR_U);
    seg_buf.insert(seg_buf.size(), 8'hff);
    seg_buf.insert(seg_buf.size(), 8'h00);
    seg_buf.insert(seg_buf.size(), 8'hff);
    seg_buf.insert(seg_buf.size(), 8'h9a);
    seg_buf.insert(seg_buf.size(), 8'h5b);
    flush_segment();
    seg_buf.insert(seg_buf.size(), 8'hff);
    flush_segment();
    wait_scan_idle();

    foreach (be_plan[p]) begin
      write_big_endian(be_plan[p]);
      @(negedge clk);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) begin
        build_segment(be_plan[p]);
      end
      wait_scan_idle();
    end

    if (mismatches == 0) begin
      $display("elf_note_build_id_scan_tb: clean");
    end else begin
      $display("elf_note_build_id_scan_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_400_000;
    $display("elf_note_build_id_scan_tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
src/enbid_pkg.sv
src/elf_note_build_id_scan.sv
src/enbid_chk.sv
verif/elf_note_build_id_scan_tb.sv
